[hdl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buffer pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_BUFS_DEF = 32;
    localparam int IDX_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int CNT_W        = 6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] buffer_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]    granted_index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    free_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

endpackage

[hdl/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/bpa_dp.sv]
// ----------------------------------------------------------------------------
// bpa_dp
// Free stack memory, allocated bitmap, depth counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_dp
    import bpa_pkg::*;
#(
    parameter int NUM_BUFS = NUM_BUFS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    input  req_t s_data,
    output rsp_t m_data
);

    localparam int DEPTH_W = $clog2(NUM_BUFS + 1);
    localparam int ADDR_W  = $clog2(NUM_BUFS);
    localparam int MAP_N   = (NUM_BUFS < 32) ? NUM_BUFS : 32;
    localparam int MAP_W   = $clog2(MAP_N);
    localparam int CMP_W   = ((DEPTH_W > IDX_W) ? DEPTH_W : IDX_W) + 1;

    logic [ADDR_W-1:0]  stack_mem [NUM_BUFS];
    logic [ADDR_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [ADDR_W-1:0]  top_addr;
    logic [ADDR_W-1:0]  pop_val;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] low_reg;
    logic [DEPTH_W-1:0] low_next;
    logic [MAP_N-1:0]   map_reg;
    logic [MAP_N-1:0]   map_next;
    req_t               req_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic idx_ok;
    logic alloc_ok;
    logic free_ok;
    logic do_pop;
    logic do_push;

    assign top_addr = ADDR_W'(depth_reg - DEPTH_W'(1));
    assign pop_val  = (DEPTH_W'(rd_addr_reg) < low_reg) ? rd_addr_reg : rd_data_reg;
    assign idx_ok   = CMP_W'(req_reg.buffer_index) < CMP_W'(NUM_BUFS);
    assign alloc_ok = depth_reg != '0;
    assign free_ok  = idx_ok && map_reg[req_reg.buffer_index[MAP_W-1:0]]
                      && (depth_reg < DEPTH_W'(NUM_BUFS));
    assign do_pop   = cmd.exec && (req_reg.opcode == OP_ALLOC) && alloc_ok;
    assign do_push  = cmd.exec && (req_reg.opcode == OP_FREE) && free_ok;

    always_ff @(posedge aclk) begin
        rd_data_reg <= stack_mem[top_addr];
        rd_addr_reg <= top_addr;
        if (do_push) begin
            stack_mem[depth_reg[ADDR_W-1:0]] <= ADDR_W'(req_reg.buffer_index);
        end
    end

    always_comb begin
        depth_next = depth_reg;
        low_next   = low_reg;
        map_next   = map_reg;
        rsp_next   = rsp_reg;
        if (cmd.exec) begin
            rsp_next.granted_index = '0;
            rsp_next.status        = ST_OK;
            if (req_reg.opcode == OP_ALLOC) begin
                if (alloc_ok) begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (depth_next < low_reg) begin
                        low_next = depth_next;
                    end
                    if (CMP_W'(pop_val) < CMP_W'(MAP_N)) begin
                        map_next[pop_val[MAP_W-1:0]] = 1'b1;
                    end
                    rsp_next.granted_index = IDX_W'(pop_val);
                end else begin
                    rsp_next.status = ST_EMPTY;
                end
            end else begin
                if (free_ok) begin
                    depth_next = depth_reg + DEPTH_W'(1);
                    map_next[req_reg.buffer_index[MAP_W-1:0]] = 1'b0;
                end else begin
                    rsp_next.status = ST_NOT_ALLOC;
                end
            end
            rsp_next.free_count = CNT_W'(depth_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= DEPTH_W'(NUM_BUFS);
            low_reg   <= DEPTH_W'(NUM_BUFS);
            map_reg   <= '0;
        end else begin
            depth_reg <= depth_next;
            low_reg   <= low_next;
            map_reg   <= map_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        rsp_reg <= rsp_next;
    end

    assign m_data = rsp_reg;

`ifndef SYNTHESIS
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(NUM_BUFS) && low_reg <= depth_reg)
        else $error("free stack depth out of range");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |=> depth_reg == $past(depth_reg) + DEPTH_W'(1))
        else $error("free did not grow the stack");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |=> depth_reg == $past(depth_reg) - DEPTH_W'(1))
        else $error("allocate did not shrink the stack");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && req_reg.opcode == OP_ALLOC && depth_reg == '0
        |=> rsp_reg.status == ST_EMPTY && rsp_reg.granted_index == '0)
        else $error("empty pool not reported");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> depth_reg == $past(depth_reg) && map_reg == $past(map_reg))
        else $error("pool state changed outside execute");
`endif

endmodule

[hdl/buffer_pool_allocator.sv]
// ----------------------------------------------------------------------------
// buffer_pool_allocator
// LIFO free-list buffer allocator with allocated bitmap and error reporting.
// ----------------------------------------------------------------------------
//  channel | ports                      | word
//  --------+----------------------------+---------------------------------
//  request | s_valid, s_ready, s_data   | opcode, buffer_index
//  result  | m_valid, m_ready, m_data   | granted_index, status, free_count
//
//  Each word passes through accept, execute and result in turn; one word in flight.
//  The registered read port of the free stack memory sets the execute cycle.
//  A result held by m_ready low holds the request side as well.
//  Reset leaves all buffers free; no clearing pass, slots never written
//  since reset read back as their own index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_pool_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_BUFS = NUM_BUFS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    cmd_t cmd;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bpa_dp #(
        .NUM_BUFS (NUM_BUFS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
